[rtl/ggnh_pkg.sv]
package ggnh_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int COORD_BITS_DEF    = 16;
	localparam int QUEUE_DEPTH       = 2;

	localparam int OP_W    = 3;
	localparam int NODE_W  = 16;
	localparam int POS_W   = 16;
	localparam int STAT_W  = 2;

	// raw op codes on the request channel
	localparam logic [OP_W-1:0] OPC_ADD   = 3'd0;
	localparam logic [OP_W-1:0] OPC_DEL   = 3'd1;
	localparam logic [OP_W-1:0] OPC_SELF  = 3'd2;
	localparam logic [OP_W-1:0] OPC_QUERY = 3'd3;
	localparam logic [OP_W-1:0] OPC_NBR   = 3'd4;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_DEL,
		OP_SELF,
		OP_QUERY,
		OP_NBR,
		OP_NOP
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK   = 2'd0,
		STAT_FULL = 2'd1,
		STAT_MISS = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_FIN,
		S_DIST,
		S_OUT
	} state_t;

	typedef struct packed {
		op_t               op;
		logic [NODE_W-1:0] node_id;
		logic [POS_W-1:0]  pos_x;
		logic [POS_W-1:0]  pos_y;
		logic [POS_W-1:0]  pos_z;
		logic              last;
	} item_t;

endpackage

[rtl/ggnh_if.sv]
interface ggnh_req_if;
	logic                         valid;
	logic                         ready;
	logic [ggnh_pkg::OP_W-1:0]    op;
	logic [ggnh_pkg::NODE_W-1:0]  node_id;
	logic [ggnh_pkg::POS_W-1:0]   pos_x;
	logic [ggnh_pkg::POS_W-1:0]   pos_y;
	logic [ggnh_pkg::POS_W-1:0]   pos_z;
	logic                         last;

	modport source(output valid, op, node_id, pos_x, pos_y, pos_z, last, input ready);
	modport sink(input valid, op, node_id, pos_x, pos_y, pos_z, last, output ready);
endinterface

interface ggnh_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [ggnh_pkg::STAT_W-1:0]  status;
	logic                         hop_valid;
	logic [ggnh_pkg::NODE_W-1:0]  next_hop;

	modport source(output valid, status, hop_valid, next_hop, input ready);
	modport sink(input valid, status, hop_valid, next_hop, output ready);
endinterface

[rtl/ggnh_dist.sv]
module ggnh_dist #(
	parameter int COORD_BITS = ggnh_pkg::COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [2:0][COORD_BITS-1:0]     a,
	input  logic [2:0][COORD_BITS-1:0]     b,
	output logic                           done,
	output logic [2*COORD_BITS+1:0]        sq_sum
);

	localparam int SQ_W   = 2 * COORD_BITS;
	localparam int DIST_W = 2 * COORD_BITS + 2;

	logic                       v_s1, v_s2, v_s3;
	logic [2:0][COORD_BITS-1:0] diff_s1;
	logic [2:0][SQ_W-1:0]       sq_s2;
	logic [DIST_W-1:0]          dist_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			diff_s1[i] <= (a[i] >= b[i]) ? (a[i] - b[i]) : (b[i] - a[i]);
			sq_s2[i]   <= SQ_W'(diff_s1[i]) * SQ_W'(diff_s1[i]);
		end
		// three squares of COORD_BITS values never carry past DIST_W
		dist_s3 <= DIST_W'(sq_s2[0]) + DIST_W'(sq_s2[1]) + DIST_W'(sq_s2[2]);
	end

	assign done   = v_s3;
	assign sq_sum = dist_s3;

endmodule

[rtl/ggnh_front.sv]
module ggnh_front (
	input  logic                 clk,
	input  logic                 arst_n,
	ggnh_req_if.sink             req,
	input  logic                 init_done,
	output logic                 q_valid,
	output ggnh_pkg::item_t      q_item,
	input  logic                 q_pop
);

	localparam int PW = $clog2(ggnh_pkg::QUEUE_DEPTH);

	ggnh_pkg::item_t fifo_q [ggnh_pkg::QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [PW:0]     count_q;
	logic            push;
	ggnh_pkg::item_t item_d;

	// classify the incoming word
	always_comb begin
		item_d.node_id = req.node_id;
		item_d.pos_x   = req.pos_x;
		item_d.pos_y   = req.pos_y;
		item_d.pos_z   = req.pos_z;
		item_d.last    = req.last;
		unique case (req.op)
			ggnh_pkg::OPC_ADD:   item_d.op = ggnh_pkg::OP_ADD;
			ggnh_pkg::OPC_DEL:   item_d.op = ggnh_pkg::OP_DEL;
			ggnh_pkg::OPC_SELF:  item_d.op = ggnh_pkg::OP_SELF;
			ggnh_pkg::OPC_QUERY: item_d.op = ggnh_pkg::OP_QUERY;
			ggnh_pkg::OPC_NBR:   item_d.op = ggnh_pkg::OP_NBR;
			default:             item_d.op = ggnh_pkg::OP_NOP;
		endcase
	end

	assign req.ready = init_done && (count_q != (PW+1)'(ggnh_pkg::QUEUE_DEPTH));
	assign push      = req.valid && req.ready;
	assign q_valid   = (count_q != '0);
	assign q_item    = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(ggnh_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (q_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(ggnh_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !q_pop)
				count_q <= count_q + 1'b1;
			else if (q_pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= item_d;
	end

endmodule

[rtl/ggnh_back.sv]
module ggnh_back #(
	parameter int TABLE_ENTRIES = ggnh_pkg::TABLE_ENTRIES_DEF,
	parameter int COORD_BITS    = ggnh_pkg::COORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  ggnh_pkg::item_t      q_item,
	output logic                 q_pop,
	output logic                 init_done,
	ggnh_rsp_if.source           rsp
);

	localparam int AW     = $clog2(TABLE_ENTRIES);
	localparam int DIST_W = 2 * COORD_BITS + 2;
	localparam int NW     = ggnh_pkg::NODE_W;

	typedef logic [2:0][COORD_BITS-1:0] pos_t;

	typedef struct packed {
		logic          valid;
		logic [NW-1:0] node;
		pos_t          pos;
	} entry_t;

	// location table
	entry_t mem_q [TABLE_ENTRIES];

	ggnh_pkg::state_t  state_q, state_d;
	ggnh_pkg::item_t   cur_q;
	logic [AW:0]       iss_q;
	logic              rd_s1;
	logic [AW-1:0]     rd_idx_s1;
	entry_t            rd_data_s1;
	logic              found_q, free_q;
	logic [AW-1:0]     slot_q, free_slot_q;
	pos_t              ent_pos_q;
	logic [NW-1:0]     self_node_q, best_hop_q;
	pos_t              self_pos_q, dest_pos_q;
	logic [DIST_W-1:0] best_dist_q;

	ggnh_pkg::status_t res_status_q;
	logic              res_hop_valid_q;
	logic [NW-1:0]     res_next_hop_q;

	logic              rsp_valid_q;
	ggnh_pkg::status_t rsp_status_q;
	logic              rsp_hop_valid_q;
	logic [NW-1:0]     rsp_next_hop_q;

	logic              rd_en, wr_en, iss_inc, scan_init;
	logic [AW-1:0]     rd_addr, wr_addr;
	entry_t            wr_data;
	logic              scan_hit, searching, cap_hit, cap_free;
	logic              set_self, set_dest, best_load, better;
	logic [DIST_W-1:0] best_dist_d;
	logic [NW-1:0]     best_hop_d, hop_sel;
	logic              res_load, rsp_load, out_free;
	ggnh_pkg::status_t res_status_d;
	logic              res_hop_valid_d;
	logic [NW-1:0]     res_next_hop_d;
	logic              dist_start, dist_done;
	pos_t              dist_a, dist_b, cur_pos;
	logic [DIST_W-1:0] dist_sum;

	assign cur_pos[0] = COORD_BITS'(cur_q.pos_x);
	assign cur_pos[1] = COORD_BITS'(cur_q.pos_y);
	assign cur_pos[2] = COORD_BITS'(cur_q.pos_z);

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign init_done = (state_q != ggnh_pkg::S_CLEAR);
	assign scan_hit  = rd_s1 && rd_data_s1.valid && (rd_data_s1.node == cur_q.node_id);

	ggnh_dist #(
		.COORD_BITS(COORD_BITS)
	) u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dist_start),
		.a      (dist_a),
		.b      (dist_b),
		.done   (dist_done),
		.sq_sum (dist_sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ggnh_pkg::S_CLEAR;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d         = state_q;
		q_pop           = 1'b0;
		rd_en           = 1'b0;
		rd_addr         = iss_q[AW-1:0];
		wr_en           = 1'b0;
		wr_addr         = rd_idx_s1;
		wr_data         = rd_data_s1;
		iss_inc         = 1'b0;
		scan_init       = 1'b0;
		searching       = 1'b0;
		cap_hit         = 1'b0;
		cap_free        = 1'b0;
		set_self        = 1'b0;
		set_dest        = 1'b0;
		best_load       = 1'b0;
		better          = 1'b0;
		best_dist_d     = dist_sum;
		best_hop_d      = cur_q.node_id;
		hop_sel         = best_hop_q;
		dist_start      = 1'b0;
		dist_a          = ent_pos_q;
		dist_b          = dest_pos_q;
		res_load        = 1'b0;
		res_status_d    = ggnh_pkg::STAT_OK;
		res_hop_valid_d = 1'b0;
		res_next_hop_d  = '0;
		rsp_load        = 1'b0;

		unique case (state_q)
			ggnh_pkg::S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = iss_q[AW-1:0];
				wr_data = '0;
				iss_inc = 1'b1;
				if (iss_q[AW-1:0] == AW'(TABLE_ENTRIES - 1))
					state_d = ggnh_pkg::S_IDLE;
			end
			ggnh_pkg::S_IDLE: begin
				if (q_valid) begin
					q_pop     = 1'b1;
					scan_init = 1'b1;
					if (q_item.op == ggnh_pkg::OP_ADD || q_item.op == ggnh_pkg::OP_DEL ||
					    q_item.op == ggnh_pkg::OP_NBR)
						state_d = ggnh_pkg::S_SCAN;
					else
						state_d = ggnh_pkg::S_FIN;
				end
			end
			ggnh_pkg::S_SCAN: begin
				// delete sweeps the whole table, add and neighbor stop on first hit
				if (cur_q.op == ggnh_pkg::OP_DEL) begin
					searching     = 1'b1;
					wr_en         = scan_hit;
					wr_data.valid = 1'b0;
				end else begin
					searching = !found_q && !scan_hit;
				end
				cap_hit  = scan_hit && !found_q;
				cap_free = (cur_q.op == ggnh_pkg::OP_ADD) && rd_s1 && !rd_data_s1.valid && !free_q;
				rd_en    = searching && (iss_q != (AW+1)'(TABLE_ENTRIES));
				iss_inc  = rd_en;
				if (!rd_en && !rd_s1)
					state_d = ggnh_pkg::S_FIN;
			end
			ggnh_pkg::S_FIN: begin
				state_d  = ggnh_pkg::S_OUT;
				res_load = 1'b1;
				unique case (cur_q.op)
					ggnh_pkg::OP_ADD: begin
						wr_en         = found_q || free_q;
						wr_addr       = found_q ? slot_q : free_slot_q;
						wr_data.valid = 1'b1;
						wr_data.node  = cur_q.node_id;
						wr_data.pos   = cur_pos;
						res_status_d  = (found_q || free_q) ? ggnh_pkg::STAT_OK
						                                    : ggnh_pkg::STAT_FULL;
					end
					ggnh_pkg::OP_DEL: begin
						res_status_d = found_q ? ggnh_pkg::STAT_OK : ggnh_pkg::STAT_MISS;
					end
					ggnh_pkg::OP_SELF: begin
						set_self = 1'b1;
					end
					ggnh_pkg::OP_QUERY: begin
						set_dest   = 1'b1;
						dist_start = 1'b1;
						dist_a     = self_pos_q;
						dist_b     = cur_pos;
						res_load   = 1'b0;
						state_d    = ggnh_pkg::S_DIST;
					end
					ggnh_pkg::OP_NBR: begin
						if (found_q) begin
							dist_start = 1'b1;
							res_load   = 1'b0;
							state_d    = ggnh_pkg::S_DIST;
						end else begin
							res_status_d    = ggnh_pkg::STAT_MISS;
							res_hop_valid_d = cur_q.last;
							res_next_hop_d  = cur_q.last ? best_hop_q : '0;
						end
					end
					default: begin
					end
				endcase
			end
			ggnh_pkg::S_DIST: begin
				if (dist_done) begin
					res_load = 1'b1;
					state_d  = ggnh_pkg::S_OUT;
					if (cur_q.op == ggnh_pkg::OP_QUERY) begin
						best_load  = 1'b1;
						best_hop_d = self_node_q;
					end else begin
						// strict compare: a tie keeps the earlier hop
						better          = dist_sum < best_dist_q;
						best_load       = better;
						hop_sel         = better ? cur_q.node_id : best_hop_q;
						res_hop_valid_d = cur_q.last;
						res_next_hop_d  = cur_q.last ? hop_sel : '0;
					end
				end
			end
			ggnh_pkg::S_OUT: begin
				if (out_free) begin
					rsp_load = 1'b1;
					state_d  = ggnh_pkg::S_IDLE;
				end
			end
			default: state_d = ggnh_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_s1 <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q       <= '0;
			rd_s1       <= 1'b0;
			found_q     <= 1'b0;
			free_q      <= 1'b0;
			self_node_q <= '0;
			self_pos_q  <= '0;
			dest_pos_q  <= '0;
			best_dist_q <= '1;
			best_hop_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_s1 <= rd_en;
			if (scan_init) begin
				iss_q   <= '0;
				found_q <= 1'b0;
				free_q  <= 1'b0;
			end else begin
				if (iss_inc)
					iss_q <= iss_q + 1'b1;
				if (cap_hit)
					found_q <= 1'b1;
				if (cap_free)
					free_q <= 1'b1;
			end
			if (set_self) begin
				self_node_q <= cur_q.node_id;
				self_pos_q  <= cur_pos;
			end
			if (set_dest)
				dest_pos_q <= cur_pos;
			if (best_load) begin
				best_dist_q <= best_dist_d;
				best_hop_q  <= best_hop_d;
			end
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_item;
		if (rd_en)
			rd_idx_s1 <= rd_addr;
		if (cap_hit) begin
			slot_q    <= rd_idx_s1;
			ent_pos_q <= rd_data_s1.pos;
		end
		if (cap_free)
			free_slot_q <= rd_idx_s1;
		if (res_load) begin
			res_status_q    <= res_status_d;
			res_hop_valid_q <= res_hop_valid_d;
			res_next_hop_q  <= res_next_hop_d;
		end
		if (rsp_load) begin
			rsp_status_q    <= res_status_q;
			rsp_hop_valid_q <= res_hop_valid_q;
			rsp_next_hop_q  <= res_next_hop_q;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = rsp_status_q;
	assign rsp.hop_valid = rsp_hop_valid_q;
	assign rsp.next_hop  = rsp_next_hop_q;

	a_no_rw_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("table read and write hit the same slot");

	a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!init_done |-> !q_pop)
		else $error("word taken during clearing pass");

	a_dist_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		dist_done |-> (state_q == ggnh_pkg::S_DIST))
		else $error("distance result outside wait state");

	a_hop_only_nbr: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && res_hop_valid_d) |-> (cur_q.op == ggnh_pkg::OP_NBR))
		else $error("hop result from a non-neighbor word");

	a_out_not_lost: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp.ready) |=> rsp_valid_q)
		else $error("pending result dropped");

endmodule

[rtl/greedy_geographic_next_hop.sv]
// Each word goes from idle through finish to out; add, delete and neighbor scan the table
// before finish, and begin query and a found neighbor wait for the distance pipeline.
// Throughput: one word in the back end at a time, the next taken the cycle after a result
// is loaded; a 2-word queue sits in front.
// Reset: async active low; then a clearing pass empties the table with req.ready held low.
module greedy_geographic_next_hop #(
	parameter int TABLE_ENTRIES = ggnh_pkg::TABLE_ENTRIES_DEF,
	parameter int COORD_BITS    = ggnh_pkg::COORD_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ggnh_req_if.sink   req,
	ggnh_rsp_if.source rsp
);

	logic            q_valid, q_pop, init_done;
	ggnh_pkg::item_t q_item;

	ggnh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.init_done (init_done),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	ggnh_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.COORD_BITS    (COORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.init_done (init_done),
		.rsp       (rsp)
	);

endmodule

[verif/greedy_geographic_next_hop_tb.sv]
module greedy_geographic_next_hop_tb;

	localparam int CLK_PERIOD   = 12;
	localparam int SLOTS        = ggnh_pkg::TABLE_ENTRIES_DEF;
	localparam int DIST_W       = 2 * ggnh_pkg::COORD_BITS_DEF + 2;
	localparam int OP_W         = ggnh_pkg::OP_W;
	localparam int NODE_W       = ggnh_pkg::NODE_W;
	localparam int POS_W        = ggnh_pkg::POS_W;
	localparam int STAT_W       = ggnh_pkg::STAT_W;
	localparam int ID_POOL      = 96;
	localparam int HOLD_CYCLES  = 1500;
	localparam int SETTLE       = 2 * ggnh_pkg::TABLE_ENTRIES_DEF + 20;
	localparam int LIMIT_CYCLES = 1500000;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [NODE_W-1:0] node_id;
		logic [POS_W-1:0]  pos_x;
		logic [POS_W-1:0]  pos_y;
		logic [POS_W-1:0]  pos_z;
		logic              last;
	} req_word_t;

	typedef struct packed {
		ggnh_pkg::status_t status;
		logic              hop_valid;
		logic [NODE_W-1:0] next_hop;
	} hop_result_t;

	// location table and query state kept alongside the block
	class route_scoreboard;
		bit                slot_used [SLOTS];
		bit [NODE_W-1:0]   slot_id [SLOTS];
		bit [POS_W-1:0]    slot_x [SLOTS];
		bit [POS_W-1:0]    slot_y [SLOTS];
		bit [POS_W-1:0]    slot_z [SLOTS];
		bit [NODE_W-1:0]   own_id;
		bit [POS_W-1:0]    own_x, own_y, own_z;
		bit [POS_W-1:0]    dst_x, dst_y, dst_z;
		bit [DIST_W-1:0]   best_d;
		bit [NODE_W-1:0]   best_id;
		hop_result_t       result_q[$];
		int                errors;
		int                words_in;
		int                hops;
		int                fulls;
		int                misses;

		function new();
			foreach (slot_used[i]) slot_used[i] = 1'b0;
			own_id = '0;
			{own_x, own_y, own_z} = '0;
			{dst_x, dst_y, dst_z} = '0;
			best_d = '1;
			best_id = '0;
		endfunction

		function bit [DIST_W-1:0] dist_to_dst(bit [POS_W-1:0] x, bit [POS_W-1:0] y,
				bit [POS_W-1:0] z);
			longint unsigned dx, dy, dz;
			dx = 64'((x >= dst_x) ? x - dst_x : dst_x - x);
			dy = 64'((y >= dst_y) ? y - dst_y : dst_y - y);
			dz = 64'((z >= dst_z) ? z - dst_z : dst_z - z);
			return DIST_W'(dx * dx + dy * dy + dz * dz);
		endfunction

		function int find_id(bit [NODE_W-1:0] id);
			for (int i = 0; i < SLOTS; i++)
				if (slot_used[i] && slot_id[i] == id) return i;
			return -1;
		endfunction

		function int pending();
			return result_q.size();
		endfunction

		function void note_word(req_word_t w);
			hop_result_t     r;
			int              slot;
			bit [DIST_W-1:0] d;
			r = '{status: ggnh_pkg::STAT_OK, hop_valid: 1'b0, next_hop: '0};
			words_in++;
			case (w.op)
				ggnh_pkg::OPC_ADD: begin
					slot = find_id(w.node_id);
					if (slot < 0)
						for (int i = 0; i < SLOTS; i++)
							if (!slot_used[i]) begin
								slot = i;
								break;
							end
					if (slot < 0) begin
						r.status = ggnh_pkg::STAT_FULL;
					end else begin
						slot_used[slot] = 1'b1;
						slot_id[slot] = w.node_id;
						slot_x[slot] = w.pos_x;
						slot_y[slot] = w.pos_y;
						slot_z[slot] = w.pos_z;
					end
				end
				ggnh_pkg::OPC_DEL: begin
					r.status = ggnh_pkg::STAT_MISS;
					for (int i = 0; i < SLOTS; i++)
						if (slot_used[i] && slot_id[i] == w.node_id) begin
							slot_used[i] = 1'b0;
							r.status = ggnh_pkg::STAT_OK;
						end
				end
				ggnh_pkg::OPC_SELF: begin
					own_id = w.node_id;
					{own_x, own_y, own_z} = {w.pos_x, w.pos_y, w.pos_z};
				end
				ggnh_pkg::OPC_QUERY: begin
					{dst_x, dst_y, dst_z} = {w.pos_x, w.pos_y, w.pos_z};
					best_d = dist_to_dst(own_x, own_y, own_z);
					best_id = own_id;
				end
				ggnh_pkg::OPC_NBR: begin
					slot = find_id(w.node_id);
					if (slot < 0) begin
						r.status = ggnh_pkg::STAT_MISS;
					end else begin
						// strictly closer only: a tie keeps the earlier candidate
						d = dist_to_dst(slot_x[slot], slot_y[slot], slot_z[slot]);
						if (d < best_d) begin
							best_d = d;
							best_id = w.node_id;
						end
					end
					if (w.last) begin
						r.hop_valid = 1'b1;
						r.next_hop = best_id;
					end
				end
				default: ;
			endcase
			if (r.hop_valid) hops++;
			if (r.status == ggnh_pkg::STAT_FULL) fulls++;
			if (r.status == ggnh_pkg::STAT_MISS) misses++;
			result_q.push_back(r);
		endfunction

		function void check_word(logic [STAT_W-1:0] status, logic hop_valid,
				logic [NODE_W-1:0] next_hop);
			hop_result_t e;
			if (result_q.size() == 0) begin
				$error("result word with nothing expected: status %0d hop_valid %0d next_hop %0h",
					status, hop_valid, next_hop);
				errors++;
				return;
			end
			e = result_q.pop_front();
			if (status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, status);
				errors++;
			end
			if (hop_valid !== e.hop_valid) begin
				$error("hop_valid: expected %0d, got %0d", e.hop_valid, hop_valid);
				errors++;
			end
			if (next_hop !== e.next_hop) begin
				$error("next_hop: expected %0h, got %0h", e.next_hop, next_hop);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ggnh_req_if req_ch();
	ggnh_rsp_if rsp_ch();

	greedy_geographic_next_hop dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	route_scoreboard sb = new();

	bit              calm;
	bit              hold_req;
	int              words_sent;
	int              pool_n;
	bit [NODE_W-1:0] known_ids [ID_POOL];

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		if (req_ch.valid && req_ch.ready)
			sb.note_word('{op: req_ch.op, node_id: req_ch.node_id, pos_x: req_ch.pos_x,
				pos_y: req_ch.pos_y, pos_z: req_ch.pos_z, last: req_ch.last});
		if (rsp_ch.valid && rsp_ch.ready)
			sb.check_word(rsp_ch.status, rsp_ch.hop_valid, rsp_ch.next_hop);
	end

	// receiver: random stalls, or one long hold-off on request
	initial begin
		int held;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				rsp_ch.ready <= 1'b0;
				held = 1;
				while (held < HOLD_CYCLES) begin
					@(posedge clk);
					held++;
				end
				hold_req = 1'b0;
			end else begin
				rsp_ch.ready <= calm || ($urandom_range(99) >= 10);
			end
		end
	end

	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("DONE: errors detected");
		$finish;
	end

	function automatic bit [POS_W-1:0] rnd_word();
		return POS_W'($urandom);
	endfunction

	function automatic bit coin();
		return 1'($urandom_range(1));
	endfunction

	function automatic bit [POS_W-1:0] pick_coord();
		int r;
		r = $urandom_range(99);
		if (r < 70) return rnd_word();
		// a few shared values make equal distances likely
		if (r < 90) return POS_W'(1000 * $urandom_range(3));
		return coin() ? 16'hFFFF : 16'h0000;
	endfunction

	function automatic bit [NODE_W-1:0] pick_id();
		int r;
		r = $urandom_range(99);
		if (r < 5) return NODE_W'($urandom);
		return known_ids[$urandom_range(pool_n - 1)];
	endfunction

	task automatic put_word(input bit [OP_W-1:0] op, input bit [NODE_W-1:0] id,
			input bit [POS_W-1:0] x, input bit [POS_W-1:0] y, input bit [POS_W-1:0] z,
			input bit last);
		if (!calm && $urandom_range(99) < 10) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.node_id <= id;
		req_ch.pos_x <= x;
		req_ch.pos_y <= y;
		req_ch.pos_z <= z;
		req_ch.last <= last;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		words_sent++;
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic send_query();
		int n;
		bit drop_last;
		n = $urandom_range(1, 6);
		drop_last = ($urandom_range(99) < 5);
		if ($urandom_range(3) == 0)
			put_word(ggnh_pkg::OPC_SELF, pick_id(), pick_coord(), pick_coord(), pick_coord(),
				coin());
		put_word(ggnh_pkg::OPC_QUERY, NODE_W'($urandom), pick_coord(), pick_coord(),
			pick_coord(), coin());
		for (int k = 0; k < n; k++)
			put_word(ggnh_pkg::OPC_NBR, pick_id(), rnd_word(), rnd_word(), rnd_word(),
				(k == n - 1) ? !drop_last : ($urandom_range(9) == 0));
	endtask

	task automatic run_random(input int count, input int add_pct, input int del_pct);
		int stop_at;
		int r;
		stop_at = words_sent + count;
		while (words_sent < stop_at) begin
			r = $urandom_range(99);
			if (r < 35)
				send_query();
			else if (r < 35 + add_pct)
				put_word(ggnh_pkg::OPC_ADD, pick_id(), pick_coord(), pick_coord(),
					pick_coord(), coin());
			else if (r < 35 + add_pct + del_pct)
				put_word(ggnh_pkg::OPC_DEL, pick_id(), rnd_word(), rnd_word(), rnd_word(),
					coin());
			else if (r < 40 + add_pct + del_pct)
				put_word(ggnh_pkg::OPC_SELF, pick_id(), pick_coord(), pick_coord(),
					pick_coord(), coin());
			else if (r < 50 + add_pct + del_pct)
				put_word(ggnh_pkg::OPC_NBR, pick_id(), rnd_word(), rnd_word(), rnd_word(),
					coin());
			else
				put_word(OP_W'($urandom_range(7)), NODE_W'($urandom), rnd_word(), rnd_word(),
					rnd_word(), coin());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		calm = 1'b0;
		hold_req = 1'b0;
		words_sent = 0;
		pool_n = 40;
		known_ids[0] = 16'h0000;
		known_ids[1] = 16'hFFFF;
		for (int i = 2; i < ID_POOL; i++) known_ids[i] = NODE_W'($urandom);
		req_ch.valid = 1'b0;
		req_ch.op = ggnh_pkg::OPC_ADD;
		req_ch.node_id = '0;
		req_ch.pos_x = '0;
		req_ch.pos_y = '0;
		req_ch.pos_z = '0;
		req_ch.last = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// unknown neighbor straight after reset still returns the held hop
		put_word(ggnh_pkg::OPC_NBR, 16'd5, 16'h0000, 16'h0000, 16'h0000, 1'b1);
		put_word(ggnh_pkg::OPC_ADD, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
		put_word(ggnh_pkg::OPC_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		put_word(ggnh_pkg::OPC_ADD, 16'h0000, 16'd100, 16'd200, 16'd300, 1'b0);
		// neighbors with no query begun compete against the all-ones best
		put_word(ggnh_pkg::OPC_NBR, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b0);
		put_word(ggnh_pkg::OPC_NBR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
		put_word(ggnh_pkg::OPC_SELF, 16'h1234, 16'd1000, 16'd1000, 16'd1000, 1'b0);
		put_word(ggnh_pkg::OPC_QUERY, 16'h0000, 16'd1000, 16'd1000, 16'd1000, 1'b0);
		put_word(ggnh_pkg::OPC_NBR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
		put_word(ggnh_pkg::OPC_ADD, 16'd7, 16'd1500, 16'd0, 16'd0, 1'b0);
		put_word(ggnh_pkg::OPC_ADD, 16'd8, 16'd0, 16'd1500, 16'd0, 1'b0);
		put_word(ggnh_pkg::OPC_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
		put_word(ggnh_pkg::OPC_NBR, 16'd8, 16'h0000, 16'h0000, 16'h0000, 1'b0);
		// equal distance: the earlier neighbor stays
		put_word(ggnh_pkg::OPC_NBR, 16'd7, 16'h0000, 16'h0000, 16'h0000, 1'b1);
		put_word(ggnh_pkg::OPC_NBR, 16'd7, 16'h0000, 16'h0000, 16'h0000, 1'b1);
		put_word(ggnh_pkg::OPC_DEL, 16'd99, 16'h0000, 16'h0000, 16'h0000, 1'b0);
		put_word(ggnh_pkg::OPC_DEL, 16'd7, 16'h0000, 16'h0000, 16'h0000, 1'b1);
		put_word(ggnh_pkg::OPC_NBR, 16'd7, 16'h0000, 16'h0000, 16'h0000, 1'b1);
		put_word(ggnh_pkg::OPC_QUERY, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		put_word(ggnh_pkg::OPC_NBR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		put_word(ggnh_pkg::OPC_NBR + 3'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		put_word(ggnh_pkg::OPC_NBR + 3'd2, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
		put_word(ggnh_pkg::OPC_NBR + 3'd3, 16'hA5A5, 16'h5A5A, 16'hA5A5, 16'h5A5A, 1'b1);
		put_word(ggnh_pkg::OPC_SELF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);

		// output held off for a long stretch while words keep coming
		hold_req = 1'b1;
		run_random(600, 25, 15);
		drain();

		// wider id pool, add-heavy, no idling: the table runs full
		calm = 1'b1;
		pool_n = ID_POOL;
		run_random(500, 35, 5);
		calm = 1'b0;
		pool_n = 60;
		hold_req = 1'b1;
		run_random(800, 25, 15);
		drain();

		if (sb.pending() != 0) begin
			$error("result words: expected %0d more, got 0", sb.pending());
			sb.errors++;
		end
		$display("run covered %0d request words, %0d routing decisions", sb.words_in, sb.hops);
		$display("table-full statuses %0d, not-found statuses %0d", sb.fulls, sb.misses);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
